[hw/rtl/hdlc_dfr_pkg.sv]
// constants, codes and the crc-16/x.25 byte update for the hdlc byte deframer
// no dependencies; imported by hdlc_byte_deframer_fcs_check
`timescale 1ns / 1ps

package hdlc_dfr_pkg;

    // frame buffer bound; the byte count saturates here
    localparam int MAX_FRAME_LEN = 1024;
    localparam int COUNT_W       = $clog2(MAX_FRAME_LEN + 1);
    localparam int LEN_W         = 10;
    localparam int BYTE_W        = 8;
    localparam int KIND_W        = 2;
    localparam int CRC_W         = 16;
    localparam int STATE_W       = 2;
    localparam int CFG_INDEX_W   = 1;
    localparam int M_TDATA_W     = ((BYTE_W + LEN_W + 7) / 8) * 8;

    // parser states
    localparam logic [STATE_W-1:0] ST_IDLE = 2'd0;
    localparam logic [STATE_W-1:0] ST_DATA = 2'd1;
    localparam logic [STATE_W-1:0] ST_ESC  = 2'd2;

    // result kinds
    localparam logic [KIND_W-1:0] KIND_BYTE    = 2'd0;
    localparam logic [KIND_W-1:0] KIND_GOOD    = 2'd1;
    localparam logic [KIND_W-1:0] KIND_BAD     = 2'd2;
    localparam logic [KIND_W-1:0] KIND_TIMEOUT = 2'd3;

    // input action codes
    localparam logic ACT_BYTE    = 1'b0;
    localparam logic ACT_TIMEOUT = 1'b1;

    // configuration register indexes
    localparam logic [CFG_INDEX_W-1:0] REG_FLAG   = 1'b0;
    localparam logic [CFG_INDEX_W-1:0] REG_ESCAPE = 1'b1;

    localparam logic [BYTE_W-1:0] FLAG_RESET   = 8'h7E;
    localparam logic [BYTE_W-1:0] ESCAPE_RESET = 8'h7D;

    localparam logic [CRC_W-1:0] CRC_PRESET  = 16'hFFFF;
    localparam logic [CRC_W-1:0] CRC_POLY    = 16'h8408;
    localparam logic [CRC_W-1:0] CRC_RESIDUE = 16'hF0B8;

    // reflected crc update over one byte, eight shift steps
    function automatic logic [CRC_W-1:0] crc_feed(input logic [CRC_W-1:0] crc,
                                                  input logic [BYTE_W-1:0] b);
        logic [CRC_W-1:0] c;
        c = crc ^ {{(CRC_W-BYTE_W){1'b0}}, b};
        for (int i = 0; i < BYTE_W; i++) begin
            if (c[0]) begin
                c = (c >> 1) ^ CRC_POLY;
            end else begin
                c = c >> 1;
            end
        end
        return c;
    endfunction

endpackage

[hw/rtl/hdlc_byte_deframer_fcs_check.sv]
// hdlc byte deframer with crc-16/x.25 frame check, top level
// depends on hdlc_dfr_pkg
`timescale 1ns / 1ps

// channel   direction  handshake                   payload
// s_        in         s_tvalid / s_tready         s_tdata rx_byte, s_tuser action
// m_        out        m_tvalid / m_tready         m_tdata data_byte, payload_length;
//                                                  m_tuser kind
// cfg_      in         cfg_valid / cfg_ready       cfg_index, cfg_data
//
// one item per cycle sustained: an input register feeds the byte-wide parse and crc
// update, whose single result lands in a result register that drives the m_ channel
// items that give no result (flags in idle, escapes) retire even while m_ tdata waits
// an item that gives a result stalls in the input register only while the result
// register is full and m_tready is low
// synchronous active-low reset: idle, count zero, crc preset, registers at defaults
// cfg_ready is always high; writes take effect on the next cycle

module hdlc_byte_deframer_fcs_check (
    input  logic                                   aclk,
    input  logic                                   aresetn,
    input  logic                                   s_tvalid,
    output logic                                   s_tready,
    input  logic [hdlc_dfr_pkg::BYTE_W-1:0]        s_tdata,    // [7:0] rx_byte
    input  logic                                   s_tuser,    // [0] action
    output logic                                   m_tvalid,
    input  logic                                   m_tready,
    output logic [hdlc_dfr_pkg::M_TDATA_W-1:0]     m_tdata,    // [7:0] data_byte,
                                                               // [17:8] payload_length
    output logic [hdlc_dfr_pkg::KIND_W-1:0]        m_tuser,    // [1:0] kind
    input  logic                                   cfg_valid,
    output logic                                   cfg_ready,
    input  logic [hdlc_dfr_pkg::CFG_INDEX_W-1:0]   cfg_index,
    input  logic [hdlc_dfr_pkg::BYTE_W-1:0]        cfg_data
);
    import hdlc_dfr_pkg::*;

    // configuration
    logic [BYTE_W-1:0] flag_reg;
    logic [BYTE_W-1:0] escape_reg;

    // input register
    logic              in_valid_reg;
    logic              in_action_reg;
    logic [BYTE_W-1:0] in_byte_reg;

    // parser state
    logic [STATE_W-1:0] state_reg,    state_next;
    logic [COUNT_W-1:0] count_reg,    count_next;
    logic [CRC_W-1:0]   crc_reg,      crc_next;
    logic [BYTE_W-1:0]  held0_reg,    held0_next;
    logic [BYTE_W-1:0]  held1_reg,    held1_next;
    logic               overflow_reg, overflow_next;

    // result register
    logic              out_valid_reg;
    logic [KIND_W-1:0] out_kind_reg,  out_kind_next;
    logic [BYTE_W-1:0] out_byte_reg,  out_byte_next;
    logic [LEN_W-1:0]  out_len_reg,   out_len_next;

    logic is_flag;
    logic is_escape;
    logic store;
    logic produce;
    logic frame_good;
    logic out_free;
    logic advance;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            flag_reg   <= FLAG_RESET;
            escape_reg <= ESCAPE_RESET;
        end else if (cfg_valid) begin
            unique case (cfg_index)
                REG_FLAG:   flag_reg   <= cfg_data;
                REG_ESCAPE: escape_reg <= cfg_data;
                default:    ;
            endcase
        end
    end

    // a result leaves the result register or it is empty
    assign out_free = !out_valid_reg || m_tready;
    // the held item retires unless its result has nowhere to go
    assign advance  = in_valid_reg && (!produce || out_free);
    assign s_tready = !in_valid_reg || advance;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tready && s_tvalid) begin
            in_action_reg <= s_tuser;
            in_byte_reg   <= s_tdata;
        end
    end

    // flag compare wins over escape compare when both match
    assign is_flag   = (in_byte_reg == flag_reg);
    assign is_escape = (in_byte_reg == escape_reg);

    assign frame_good = (count_reg > COUNT_W'(2)) && !overflow_reg &&
                        (crc_reg == CRC_RESIDUE);

    always_comb begin
        state_next    = state_reg;
        count_next    = count_reg;
        crc_next      = crc_reg;
        held0_next    = held0_reg;
        held1_next    = held1_reg;
        overflow_next = overflow_reg;
        out_kind_next = KIND_BYTE;
        out_byte_next = '0;
        out_len_next  = '0;
        store         = 1'b0;
        produce       = 1'b0;

        if (in_action_reg == ACT_TIMEOUT) begin
            state_next    = ST_IDLE;
            count_next    = '0;
            crc_next      = CRC_PRESET;
            held0_next    = '0;
            held1_next    = '0;
            overflow_next = 1'b0;
            out_kind_next = KIND_TIMEOUT;
            produce       = 1'b1;
        end else begin
            unique case (state_reg)
                ST_IDLE: begin
                    // an escape here is an ordinary data byte
                    if (!is_flag) begin
                        state_next = ST_DATA;
                        store      = 1'b1;
                    end
                end
                ST_DATA: begin
                    if (is_flag) begin
                        // empty frame: nothing to report
                        if (count_reg != '0) begin
                            count_next    = '0;
                            crc_next      = CRC_PRESET;
                            held0_next    = '0;
                            held1_next    = '0;
                            overflow_next = 1'b0;
                            out_kind_next = frame_good ? KIND_GOOD : KIND_BAD;
                            out_len_next  = frame_good ?
                                            LEN_W'(count_reg - COUNT_W'(2)) : '0;
                            produce       = 1'b1;
                        end
                    end else if (is_escape) begin
                        state_next = ST_ESC;
                    end else begin
                        store = 1'b1;
                    end
                end
                default: begin
                    // byte after escape is taken literally, even a flag
                    state_next = ST_DATA;
                    store      = 1'b1;
                end
            endcase

            if (store) begin
                // bytes come out two late so the fcs never leaves
                if (count_reg >= COUNT_W'(2)) begin
                    out_kind_next = KIND_BYTE;
                    out_byte_next = held0_reg;
                    produce       = 1'b1;
                end
                held0_next = held1_reg;
                held1_next = in_byte_reg;
                crc_next   = crc_feed(crc_reg, in_byte_reg);
                if (count_reg >= COUNT_W'(MAX_FRAME_LEN)) begin
                    overflow_next = 1'b1;
                end else begin
                    count_next = count_reg + COUNT_W'(1);
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            count_reg    <= '0;
            crc_reg      <= CRC_PRESET;
            held0_reg    <= '0;
            held1_reg    <= '0;
            overflow_reg <= 1'b0;
        end else if (advance) begin
            state_reg    <= state_next;
            count_reg    <= count_next;
            crc_reg      <= crc_next;
            held0_reg    <= held0_next;
            held1_reg    <= held1_next;
            overflow_reg <= overflow_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (out_free) begin
            out_valid_reg <= advance && produce;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_free && advance && produce) begin
            out_kind_reg <= out_kind_next;
            out_byte_reg <= out_byte_next;
            out_len_reg  <= out_len_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_kind_reg;
    assign m_tdata  = {{(M_TDATA_W-BYTE_W-LEN_W){1'b0}}, out_len_reg, out_byte_reg};

    // count saturates at the buffer bound
    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= COUNT_W'(MAX_FRAME_LEN))
        else $error("byte count beyond buffer bound");

    // overflow only once the count has saturated
    a_overflow_sat: assert property (@(posedge aclk) disable iff (!aresetn)
        overflow_reg |-> (count_reg == COUNT_W'(MAX_FRAME_LEN)))
        else $error("overflow mark without saturated count");

    // a retired timeout leaves the parser idle with a cleared frame
    a_timeout_clear: assert property (@(posedge aclk) disable iff (!aresetn)
        (advance && in_action_reg == ACT_TIMEOUT) |=>
        (state_reg == ST_IDLE && count_reg == '0 && !overflow_reg &&
         crc_reg == CRC_PRESET))
        else $error("timeout did not clear the frame");

    // only payload results carry a byte, only good frames a length
    a_result_fields: assert property (@(posedge aclk) disable iff (!aresetn)
        out_valid_reg |->
        ((out_kind_reg == KIND_BYTE || out_byte_reg == '0) &&
         (out_kind_reg == KIND_GOOD || out_len_reg == '0)))
        else $error("result fields not zero for this kind");

    // a held item that owes a result never retires into a full, stalled output
    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        (out_valid_reg && !m_tready) |=> $stable(out_kind_reg) && $stable(out_len_reg))
        else $error("result register changed while stalled");

endmodule

[dv/hdlc_byte_deframer_fcs_check_tb.sv]
// self-checking testbench for hdlc_byte_deframer_fcs_check: a directed stimulus table, then
// random frames under several flag and escape settings, results checked vs table or model
// depends on hdlc_dfr_pkg and the deframer rtl
`timescale 1ns / 1ps

module hdlc_byte_deframer_fcs_check_tb;
    import hdlc_dfr_pkg::*;

    localparam int PHASE_ITEMS     = 150;      // random items per settings phase
    localparam int N_PHASES        = 6;
    localparam int HOLD_PHASE      = 1;        // receiver holds off at the start of this phase
    localparam int PAUSE_PHASE     = 2;        // sender waits for all results half way through
    localparam int CALM_PHASE      = 3;        // no idling on either side
    localparam int HOLD_OFF_CYCLES = 400;
    localparam int IDLE_PCT        = 28;
    localparam int RUN_LIMIT_NS    = 1_000_000;
    localparam int PRINT_CAP       = 100;

    localparam logic TYPED     = 1'b1;         // table row carries its own expectation
    localparam logic PREDICTED = 1'b0;

    typedef enum int {
        FAULT_NONE,
        FAULT_FLIP,
        FAULT_TRUNCATE,
        FAULT_TIMEOUT,
        FAULT_NO_ESCAPE
    } frame_fault_t;

    typedef struct packed {
        logic [KIND_W-1:0] kind;
        logic [BYTE_W-1:0] data;
        logic [LEN_W-1:0]  len;
    } deframe_result_t;

    typedef struct packed {
        logic              act;
        logic [BYTE_W-1:0] rx;
        logic              typed;
        logic              has_res;
        deframe_result_t   res;
    } stim_row_t;

    logic                   aclk;
    logic                   aresetn;
    logic                   s_tvalid;
    logic                   s_tready;
    logic [BYTE_W-1:0]      s_tdata;
    logic                   s_tuser;
    logic                   m_tvalid;
    logic                   m_tready;
    logic [M_TDATA_W-1:0]   m_tdata;
    logic [KIND_W-1:0]      m_tuser;
    logic                   cfg_valid;
    logic                   cfg_ready;
    logic [CFG_INDEX_W-1:0] cfg_index;
    logic [BYTE_W-1:0]      cfg_data;

    // deframer model state and its copy of the registers
    logic [STATE_W-1:0] fr_state;
    logic [COUNT_W-1:0] fr_count;
    logic [CRC_W-1:0]   fr_crc;
    logic [BYTE_W-1:0]  fr_held [2];
    logic               fr_overflow;
    logic [BYTE_W-1:0]  flag_byte;
    logic [BYTE_W-1:0]  escape_byte;

    deframe_result_t expected_q [$];
    stim_row_t       stim_rows [$];

    int tx_idle_pct = IDLE_PCT;
    int rx_idle_pct = IDLE_PCT;
    int hold_reqs   = 0;
    int items_sent  = 0;
    int results_seen = 0;
    int mismatches  = 0;

    hdlc_byte_deframer_fcs_check dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),      // [7:0] rx_byte
        .s_tuser   (s_tuser),      // [0] action
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),      // [7:0] data_byte, [17:8] payload_length
        .m_tuser   (m_tuser),      // [1:0] kind
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // 2 ns clock
    initial aclk = 1'b0;
    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    // ------------------------------------------------------------------
    // model of the deframer
    // ------------------------------------------------------------------

    // crc-16/x.25, reflected, one input bit at a time
    function automatic logic [CRC_W-1:0] x25_next(input logic [CRC_W-1:0] crc,
                                                  input logic [BYTE_W-1:0] b);
        logic [CRC_W-1:0] c;
        logic             fb;
        c = crc;
        for (int i = 0; i < BYTE_W; i++) begin
            fb = c[0] ^ b[i];
            c  = c >> 1;
            if (fb) begin
                c = c ^ CRC_POLY;
            end
        end
        return c;
    endfunction

    task automatic restart_frame();
        fr_count    = '0;
        fr_crc      = CRC_PRESET;
        fr_held[0]  = '0;
        fr_held[1]  = '0;
        fr_overflow = 1'b0;
    endtask

    // a stored byte pushes out the one held two places back
    task automatic store_frame_byte(input logic [BYTE_W-1:0] b, output logic has,
                                    output deframe_result_t r);
        has = 1'b0;
        r   = '0;
        if (fr_count >= COUNT_W'(2)) begin
            has    = 1'b1;
            r.kind = KIND_BYTE;
            r.data = fr_held[0];
        end
        fr_held[0] = fr_held[1];
        fr_held[1] = b;
        fr_crc     = x25_next(fr_crc, b);
        // count saturates at the buffer bound, the frame is then marked bad
        if (fr_count >= COUNT_W'(MAX_FRAME_LEN)) begin
            fr_overflow = 1'b1;
        end else begin
            fr_count = fr_count + COUNT_W'(1);
        end
    endtask

    task automatic deframe_step(input logic act, input logic [BYTE_W-1:0] b,
                                output logic has, output deframe_result_t r);
        logic good;
        has = 1'b0;
        r   = '0;
        if (act == ACT_TIMEOUT) begin
            fr_state = ST_IDLE;
            restart_frame();
            has    = 1'b1;
            r.kind = KIND_TIMEOUT;
        end else begin
            case (fr_state)
                ST_IDLE: begin
                    // flag in idle is dropped, anything else (escape too) opens a frame
                    if (b != flag_byte) begin
                        fr_state = ST_DATA;
                        store_frame_byte(b, has, r);
                    end
                end
                ST_DATA: begin
                    // flag test wins when flag and escape are equal
                    if (b == flag_byte) begin
                        if (fr_count != '0) begin
                            good = fr_count > COUNT_W'(2) && !fr_overflow &&
                                   fr_crc == CRC_RESIDUE;
                            has    = 1'b1;
                            r.kind = good ? KIND_GOOD : KIND_BAD;
                            r.len  = good ? LEN_W'(fr_count - COUNT_W'(2)) : '0;
                            restart_frame();
                        end
                    end else if (b == escape_byte) begin
                        fr_state = ST_ESC;
                    end else begin
                        store_frame_byte(b, has, r);
                    end
                end
                default: begin
                    // escaped byte taken as it is, no xor
                    fr_state = ST_DATA;
                    store_frame_byte(b, has, r);
                end
            endcase
        end
    endtask

    // ------------------------------------------------------------------
    // drivers
    // ------------------------------------------------------------------

    // offer one item with random gaps in front, return once accepted
    task automatic drive_item(input logic act, input logic [BYTE_W-1:0] b);
        while ($urandom_range(99, 0) < tx_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= act;
        s_tdata  <= b;
        @(posedge aclk);
        while (s_tready !== 1'b1) begin
            @(posedge aclk);
        end
        items_sent++;
    endtask

    task automatic feed(input logic act, input logic [BYTE_W-1:0] b);
        logic            has;
        deframe_result_t r;
        deframe_step(act, b, has, r);
        if (has) begin
            expected_q.push_back(r);
        end
        drive_item(act, b);
    endtask

    task automatic add_row(input logic act, input logic [BYTE_W-1:0] rx, input logic typed,
                           input logic has, input logic [KIND_W-1:0] kind,
                           input logic [BYTE_W-1:0] data, input logic [LEN_W-1:0] len);
        stim_row_t row;
        row.act     = act;
        row.rx      = rx;
        row.typed   = typed;
        row.has_res = has;
        row.res     = '{kind: kind, data: data, len: len};
        stim_rows.push_back(row);
    endtask

    // block idle: nothing in flight, then room for items that give no result
    task automatic wait_results_drained();
        s_tvalid <= 1'b0;
        while (expected_q.size() != 0) begin
            @(posedge aclk);
        end
        repeat (4) @(posedge aclk);
    endtask

    // both registers, back to back on the config channel
    task automatic apply_settings(input logic [BYTE_W-1:0] flag_v,
                                  input logic [BYTE_W-1:0] esc_v);
        cfg_valid <= 1'b1;
        cfg_index <= REG_FLAG;
        cfg_data  <= flag_v;
        @(posedge aclk);
        while (cfg_ready !== 1'b1) begin
            @(posedge aclk);
        end
        flag_byte = flag_v;
        cfg_index <= REG_ESCAPE;
        cfg_data  <= esc_v;
        @(posedge aclk);
        while (cfg_ready !== 1'b1) begin
            @(posedge aclk);
        end
        escape_byte = esc_v;
        cfg_valid <= 1'b0;
    endtask

    // payload with fcs appended low byte first, escaped, closed by a flag
    task automatic send_frame(input int n_payload, input frame_fault_t fault,
                              input bit open_flag);
        logic [BYTE_W-1:0] body [$];
        logic [CRC_W-1:0]  fcs;
        logic [BYTE_W-1:0] v;
        int                cut;
        int                last;
        int                i;
        fcs = CRC_PRESET;
        for (i = 0; i < n_payload; i++) begin
            // lean on the flag and escape values so escaping gets plenty of use
            case ($urandom_range(7, 0))
                0: v = flag_byte;
                1: v = escape_byte;
                default: v = 8'($urandom);
            endcase
            body.push_back(v);
            fcs = x25_next(fcs, v);
        end
        fcs = ~fcs;
        body.push_back(fcs[7:0]);
        body.push_back(fcs[15:8]);
        cut  = $urandom_range(body.size() - 1, 0);
        last = (fault == FAULT_TRUNCATE) ? cut : body.size();
        if (fault == FAULT_FLIP) begin
            body[cut] = body[cut] ^ (8'h01 << $urandom_range(7, 0));
        end
        if (open_flag) begin
            feed(ACT_BYTE, flag_byte);
        end
        for (i = 0; i < last; i++) begin
            if (fault == FAULT_TIMEOUT && i == cut) begin
                feed(ACT_TIMEOUT, 8'($urandom));
            end
            if ((body[i] == flag_byte || body[i] == escape_byte) &&
                !(fault == FAULT_NO_ESCAPE && i == cut)) begin
                feed(ACT_BYTE, escape_byte);
            end
            feed(ACT_BYTE, body[i]);
        end
        feed(ACT_BYTE, flag_byte);
    endtask

    // ------------------------------------------------------------------
    // receiver: random back-pressure, plus long hold-offs on request
    // ------------------------------------------------------------------
    initial begin : result_sink
        int holds_done;
        holds_done = 0;
        m_tready <= 1'b0;
        forever begin
            @(posedge aclk);
            if (holds_done != hold_reqs) begin
                holds_done++;
                m_tready <= 1'b0;
                repeat (HOLD_OFF_CYCLES) @(posedge aclk);
            end
            m_tready <= ($urandom_range(99, 0) >= rx_idle_pct);
        end
    end

    // ------------------------------------------------------------------
    // result checking, oldest expectation first
    // ------------------------------------------------------------------
    task automatic note_mismatch(input string what, input int got, input int want);
        if (mismatches < PRINT_CAP) begin
            $display("%0t ns result %0d: %s got 0x%0h expected 0x%0h",
                     $time, results_seen, what, got, want);
        end
        mismatches++;
    endtask

    always @(posedge aclk) begin : result_check
        deframe_result_t want;
        if (aresetn === 1'b1 && m_tvalid === 1'b1 && m_tready === 1'b1) begin
            if (expected_q.size() == 0) begin
                note_mismatch("result with none expected, kind", int'(m_tuser), 0);
            end else begin
                want = expected_q.pop_front();
                if (m_tuser !== want.kind) begin
                    note_mismatch("kind", int'(m_tuser), int'(want.kind));
                end
                if (m_tdata[BYTE_W-1:0] !== want.data) begin
                    note_mismatch("data_byte", int'(m_tdata[BYTE_W-1:0]), int'(want.data));
                end
                if (m_tdata[BYTE_W +: LEN_W] !== want.len) begin
                    note_mismatch("payload_length", int'(m_tdata[BYTE_W +: LEN_W]),
                                  int'(want.len));
                end
            end
            results_seen++;
        end
    end

    // hang guard
    initial begin
        #(RUN_LIMIT_NS);
        $display("hdlc_byte_deframer_fcs_check: mismatch");
        $finish;
    end

    // ------------------------------------------------------------------
    // stimulus
    // ------------------------------------------------------------------
    initial begin : stimulus
        logic              has;
        deframe_result_t   r;
        logic [BYTE_W-1:0] new_flag;
        logic [BYTE_W-1:0] new_esc;
        int                ph;
        int                phase_start;
        int                pick;
        int                n_len;
        int                burst;
        bit                paused;

        aresetn   <= 1'b0;
        s_tvalid  <= 1'b0;
        s_tdata   <= '0;
        s_tuser   <= ACT_BYTE;
        cfg_valid <= 1'b0;
        cfg_index <= REG_FLAG;
        cfg_data  <= '0;
        flag_byte   = FLAG_RESET;
        escape_byte = ESCAPE_RESET;
        fr_state    = ST_IDLE;
        restart_frame();
        paused = 1'b0;

        // directed table, run at the reset settings (flag 7e, escape 7d)
        add_row(ACT_BYTE,    8'h7E, TYPED, 1'b0, KIND_BYTE, 8'h00, 10'd0);  // flag in idle
        add_row(ACT_TIMEOUT, 8'hA5, TYPED, 1'b1, KIND_TIMEOUT, 8'h00, 10'd0);
        add_row(ACT_BYTE,    8'h7D, TYPED, 1'b0, KIND_BYTE, 8'h00, 10'd0);  // escape in idle
        add_row(ACT_BYTE,    8'h00, TYPED, 1'b0, KIND_BYTE, 8'h00, 10'd0);
        add_row(ACT_BYTE,    8'h7E, TYPED, 1'b1, KIND_BAD, 8'h00, 10'd0);   // short frame
        add_row(ACT_BYTE,    8'h7E, TYPED, 1'b0, KIND_BYTE, 8'h00, 10'd0);  // empty frame
        add_row(ACT_BYTE,    8'h7D, TYPED, 1'b0, KIND_BYTE, 8'h00, 10'd0);  // escape in data
        add_row(ACT_BYTE,    8'h7E, TYPED, 1'b0, KIND_BYTE, 8'h00, 10'd0);  // literal flag
        add_row(ACT_BYTE,    8'hFF, TYPED, 1'b0, KIND_BYTE, 8'h00, 10'd0);
        add_row(ACT_BYTE,    8'h80, TYPED, 1'b1, KIND_BYTE, 8'h7E, 10'd0);  // held byte out
        add_row(ACT_BYTE,    8'h7E, PREDICTED, 1'b0, KIND_BYTE, 8'h00, 10'd0);  // bad fcs
        add_row(ACT_TIMEOUT, 8'h5A, TYPED, 1'b1, KIND_TIMEOUT, 8'h00, 10'd0);
        // "123456789" with its x.25 fcs, a good frame of nine bytes
        for (int i = 0; i < 9; i++) begin
            add_row(ACT_BYTE, 8'(8'h31 + i), PREDICTED, 1'b0, KIND_BYTE, 8'h00, 10'd0);
        end
        add_row(ACT_BYTE,    8'h6E, PREDICTED, 1'b0, KIND_BYTE, 8'h00, 10'd0);
        add_row(ACT_BYTE,    8'h90, PREDICTED, 1'b0, KIND_BYTE, 8'h00, 10'd0);
        add_row(ACT_BYTE,    8'h7E, PREDICTED, 1'b0, KIND_BYTE, 8'h00, 10'd0);
        add_row(ACT_TIMEOUT, 8'hFF, TYPED, 1'b1, KIND_TIMEOUT, 8'h00, 10'd0);

        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        foreach (stim_rows[k]) begin
            deframe_step(stim_rows[k].act, stim_rows[k].rx, has, r);
            if (stim_rows[k].typed) begin
                has = stim_rows[k].has_res;
                r   = stim_rows[k].res;
            end
            if (has) begin
                expected_q.push_back(r);
            end
            drive_item(stim_rows[k].act, stim_rows[k].rx);
        end
        wait_results_drained();

        // random phases, one flag/escape setting each
        for (ph = 0; ph < N_PHASES; ph++) begin
            case (ph)
                0: begin new_flag = 8'h7E; new_esc = 8'h7D; end
                1: begin new_flag = 8'h00; new_esc = 8'hFF; end
                2: begin new_flag = 8'hFF; new_esc = 8'h00; end
                3: begin new_flag = 8'h55; new_esc = 8'h55; end   // equal values
                4: begin new_flag = 8'($urandom); new_esc = 8'($urandom); end
                default: begin new_flag = FLAG_RESET; new_esc = ESCAPE_RESET; end
            endcase
            apply_settings(new_flag, new_esc);
            tx_idle_pct = (ph == CALM_PHASE) ? 0 : IDLE_PCT;
            rx_idle_pct = (ph == CALM_PHASE) ? 0 : IDLE_PCT;
            if (ph == HOLD_PHASE) begin
                hold_reqs++;
            end
            phase_start = items_sent;
            while (items_sent - phase_start < PHASE_ITEMS) begin
                if (ph == PAUSE_PHASE && !paused &&
                    items_sent - phase_start > PHASE_ITEMS / 2) begin
                    wait_results_drained();
                    paused = 1'b1;
                end
                pick  = $urandom_range(99, 0);
                n_len = ($urandom_range(9, 0) == 0) ? $urandom_range(60, 13)
                                                    : $urandom_range(12, 0);
                if (pick < 70) begin
                    send_frame(n_len, FAULT_NONE, $urandom_range(1, 0));
                end else if (pick < 85) begin
                    send_frame(n_len, frame_fault_t'($urandom_range(FAULT_NO_ESCAPE,
                                                                    FAULT_FLIP)),
                               $urandom_range(1, 0));
                end else if (pick < 94) begin
                    // line noise, now and then a timeout in it
                    burst = $urandom_range(6, 1);
                    repeat (burst) begin
                        if ($urandom_range(15, 0) == 0) begin
                            feed(ACT_TIMEOUT, 8'($urandom));
                        end else begin
                            feed(ACT_BYTE, 8'($urandom));
                        end
                    end
                end else begin
                    feed(ACT_TIMEOUT, 8'($urandom));
                end
            end
            wait_results_drained();
        end

        repeat (8) @(posedge aclk);
        if (mismatches == 0) begin
            $display("hdlc_byte_deframer_fcs_check: match");
        end else begin
            $display("hdlc_byte_deframer_fcs_check: mismatch");
        end
        $finish;
    end

endmodule

[hdlc_byte_deframer_fcs_check.f]
hw/rtl/hdlc_dfr_pkg.sv
hw/rtl/hdlc_byte_deframer_fcs_check.sv
dv/hdlc_byte_deframer_fcs_check_tb.sv
